/* rtl/core/phc_pkg.sv */
// phc_pkg: shared types and constants for the point height colormap
// used by the front, queue, back and top level modules; no dependencies
`timescale 1ns / 1ps

package phc_pkg;

  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_MEASURE = 2'd1;
  localparam logic [1:0] ACT_COLOR   = 2'd2;

  localparam int PHC_QUEUE_DEPTH = 2;

  localparam int Z_W    = 32;
  localparam int DIFF_W = Z_W + 1;
  localparam int LVL_W  = 8;
  localparam int REM_W  = 42;
  localparam int DIV_STEPS = LVL_W;

  localparam logic [LVL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [LVL_W-1:0] RAMP_SPLIT = 8'd128;

  // one color item waiting for the back end
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;   // z - lowest
    logic [Z_W-1:0]           range;  // highest - lowest
  } color_job_t;

endpackage

/* rtl/core/point_height_colormap.sv */
// point_height_colormap: top level, colors lidar points by height
// depends on phc_pkg, phc_front, phc_queue, phc_back
`timescale 1ns / 1ps

// Clear and measure items are handled in the front end and return
// nothing. A color item returns one rgb item; the back end writes it
// directly for z at or below the minimum, at or above the maximum, or for
// an empty range, and otherwise loads the shared restoring divider, forms
// its 8 quotient bits and writes the result out. It takes a new color item
// only when idle and its output is empty or popped. The height range seen
// by a color item is the one in place when it is accepted; up to
// QUEUE_DEPTH color items wait between the two ends, and while that queue
// is full, full holds back every item, clear and measure included.

module point_height_colormap
  import phc_pkg::*;
#(
  parameter int QUEUE_DEPTH = PHC_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_action,
  input  logic signed [Z_W-1:0] in_z_value,
  output logic                  empty,
  input  logic                  pop,
  output logic [LVL_W-1:0]      out_red,
  output logic [LVL_W-1:0]      out_green,
  output logic [LVL_W-1:0]      out_blue
);

  logic       job_wr, job_rd, job_full, job_empty;
  color_job_t job_in, job_out;

  phc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_action (in_action),
    .in_z_value(in_z_value),
    .job_wr    (job_wr),
    .job_data  (job_in),
    .job_full  (job_full)
  );

  phc_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_wr),
    .wr_data(job_in),
    .rd_en  (job_rd),
    .rd_data(job_out),
    .q_full (job_full),
    .q_empty(job_empty)
  );

  phc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job_data (job_out),
    .job_rd   (job_rd),
    .empty    (empty),
    .pop      (pop),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
  );

endmodule

/* rtl/core/phc_queue.sv */
// phc_queue: short queue of color jobs between front and back
// depends on phc_pkg
`timescale 1ns / 1ps

module phc_queue
  import phc_pkg::*;
#(
  parameter int QUEUE_DEPTH = PHC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  color_job_t wr_data,
  input  logic       rd_en,
  output color_job_t rd_data,
  output logic       q_full,
  output logic       q_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  color_job_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/phc_front.sv */
// phc_front: accepts items, tracks the running height range, issues color jobs
// depends on phc_pkg
`timescale 1ns / 1ps

module phc_front
  import phc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_action,
  input  logic signed [Z_W-1:0] in_z_value,
  output logic                  job_wr,
  output color_job_t            job_data,
  input  logic                  job_full
);

  logic signed [Z_W-1:0] lowest_r, lowest_nxt;
  logic signed [Z_W-1:0] highest_r, highest_nxt;
  logic                  started_r, started_nxt;
  logic                  accept;
  logic [DIFF_W-1:0]     range_wide;

  assign full   = job_full;
  assign accept = push && !job_full;
  assign job_wr = accept && (in_action == ACT_COLOR);

  assign job_data.diff = DIFF_W'(in_z_value) - DIFF_W'(lowest_r);
  assign range_wide    = DIFF_W'(highest_r) - DIFF_W'(lowest_r);
  assign job_data.range = range_wide[Z_W-1:0];

  always_comb begin
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    started_nxt = started_r;
    if (accept) begin
      case (in_action)
        ACT_CLEAR: begin
          lowest_nxt  = '0;
          highest_nxt = '0;
          started_nxt = 1'b0;
        end
        ACT_MEASURE: begin
          started_nxt = 1'b1;
          if (!started_r) begin
            lowest_nxt  = in_z_value;
            highest_nxt = in_z_value;
          end else begin
            if (in_z_value < lowest_r) begin
              lowest_nxt = in_z_value;
            end
            if (in_z_value > highest_r) begin
              highest_nxt = in_z_value;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= '0;
      highest_r <= '0;
      started_r <= 1'b0;
    end else begin
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

/* rtl/core/phc_back.sv */
// phc_back: turns color jobs into a level, with a bit-serial divider where needed, then rgb
// depends on phc_pkg
`timescale 1ns / 1ps

module phc_back
  import phc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_empty,
  input  color_job_t       job_data,
  output logic             job_rd,
  output logic             empty,
  input  logic             pop,
  output logic [LVL_W-1:0] out_red,
  output logic [LVL_W-1:0] out_green,
  output logic [LVL_W-1:0] out_blue
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [DIFF_W-1:0] ROUND_HALF = DIFF_W'(32768);

  logic [1:0]       state_r, state_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [REM_W-1:0] dv_r, dv_nxt;
  logic [LVL_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0] red_r, green_r, blue_r;

  logic             out_free, load_out;
  logic [LVL_W-1:0] load_lvl;
  logic             diff_pos, ge;
  logic [Z_W-1:0]   diff_mag;
  logic [DIFF_W-1:0] round_sum;
  logic [REM_W-1:0] numer;
  logic [LVL_W-1:0] ramp_red, ramp_green, ramp_blue;
  logic [LVL_W-1:0] lvl_x2;

  assign out_free  = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  assign diff_pos  = !job_data.diff[DIFF_W-1] && (job_data.diff != '0);
  assign diff_mag  = job_data.diff[Z_W-1:0];
  assign round_sum = {1'b0, diff_mag} + ROUND_HALF;
  // 510 * d + r, numerator of the rounded quotient over 2r
  assign numer = (REM_W'(diff_mag) << 9) - (REM_W'(diff_mag) << 1) + REM_W'(job_data.range);
  assign ge    = (rem_r >= dv_r);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    job_rd    = 1'b0;
    load_out  = 1'b0;
    load_lvl  = '0;
    case (state_r)
      S_IDLE: begin
        if (!job_empty && out_free) begin
          job_rd = 1'b1;
          if (!diff_pos) begin
            load_out = 1'b1;
            load_lvl = '0;
          end else if (job_data.range == '0) begin
            load_out = 1'b1;
            load_lvl = (round_sum[DIFF_W-1:16] > 17'(LEVEL_MAX)) ? LEVEL_MAX
                                                                 : round_sum[23:16];
          end else if (diff_mag >= job_data.range) begin
            load_out = 1'b1;
            load_lvl = LEVEL_MAX;
          end else begin
            rem_nxt   = numer;
            dv_nxt    = REM_W'({job_data.range, 1'b0}) << (DIV_STEPS - 1);
            quo_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = ge ? (rem_r - dv_r) : rem_r;
        quo_nxt = {quo_r[LVL_W-2:0], ge};
        dv_nxt  = dv_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_lvl  = quo_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // blue-green-red ramp
  always_comb begin
    lvl_x2 = {load_lvl[LVL_W-2:0], 1'b0};
    if (load_lvl < RAMP_SPLIT) begin
      ramp_red   = '0;
      ramp_green = lvl_x2;
      ramp_blue  = LEVEL_MAX - lvl_x2;
    end else begin
      ramp_red   = lvl_x2;
      ramp_green = LEVEL_MAX - lvl_x2;
      ramp_blue  = '0;
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (pop ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    quo_r <= quo_nxt;
    if (load_out) begin
      red_r   <= ramp_red;
      green_r <= ramp_green;
      blue_r  <= ramp_blue;
    end
  end

endmodule
